/* hw/rtl/skf_pkg.sv */
// shared types and constants for the scalar kalman tilt filter
// no dependencies; used by every rtl file of the block but skf_if.sv

package skf_pkg;

  typedef logic [31:0] fx_t;

  localparam int unsigned ONE_FX         = 65536;
  localparam int unsigned SAMPLE_RATE_HZ = 250;
  localparam int unsigned PROCESS_NOISE  = 655;

  // dt in 16.16, rounded to the nearest count
  localparam int unsigned STEP_DT_INT   = (ONE_FX + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
  // q*dt, truncated like the datapath multiply
  localparam int unsigned COV_STEP_INT  = (PROCESS_NOISE * STEP_DT_INT) / ONE_FX;

  localparam fx_t ONE       = fx_t'(ONE_FX);
  localparam fx_t STEP_DT   = fx_t'(STEP_DT_INT);
  localparam fx_t COV_STEP  = fx_t'(COV_STEP_INT);
  localparam fx_t COV_RESET = 32'd6553600;

  localparam int unsigned NOISE_W = 31;
  localparam logic [NOISE_W-1:0] NOISE_RESET = 31'd6554;

  // gain saturation on a zero divisor
  localparam fx_t GAIN_SAT_POS = 32'h7FFF_FFFF;
  localparam fx_t GAIN_SAT_NEG = 32'h8000_0000;

  // dividend is |a| << 16, so the quotient needs 48 bits
  localparam int unsigned DIV_BITS  = 48;
  localparam int unsigned DIV_CNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_DELTA,
    S_ADD_DELTA,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL_INNOV,
    S_ADD_INNOV,
    S_MUL_PA,
    S_MUL_GG,
    S_MUL_RC,
    S_ADD_COV,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/skf_if.sv */
// valid/ready channel interfaces for the filter's sample and result streams
// depends on nothing but the field widths of the block

interface skf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gyro_rate;
  logic signed [31:0] measured_angle;
  logic               run_update;

  modport source (output valid, output gyro_rate, output measured_angle,
                  output run_update, input ready);
  modport sink   (input valid, input gyro_rate, input measured_angle,
                  input run_update, output ready);
endinterface

interface skf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] gyro_only_angle;

  modport source (output valid, output angle_estimate, output gyro_only_angle,
                  input ready);
  modport sink   (input valid, input angle_estimate, input gyro_only_angle,
                  output ready);
endinterface

/* hw/rtl/skf_mul.sv */
// shared 16.16 fixed point multiplier with registered result
// depends on skf_pkg for the value type

module skf_mul (
  input  logic          clk,
  input  skf_pkg::fx_t  a,
  input  skf_pkg::fx_t  b,
  output skf_pkg::fx_t  product
);

  logic signed [63:0] full;

  assign full = $signed(a) * $signed(b);

  // floor shift by 16, keep the low 32 bits
  always_ff @(posedge clk) begin
    product <= full[47:16];
  end

endmodule

/* hw/rtl/skf_div.sv */
// radix-2 restoring divider for the gain: (a << 16) / b, truncated toward zero
// depends on skf_pkg for widths, saturation codes and the status struct

module skf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  skf_pkg::fx_t         numer,
  input  skf_pkg::fx_t         denom,
  output skf_pkg::fx_t         quotient,
  output skf_pkg::div_status_t status
);

  logic [skf_pkg::DIV_BITS-1:0]  quo;
  logic [31:0]                   rem;
  logic [31:0]                   dmag;
  logic                          neg;
  logic [skf_pkg::DIV_CNT_W-1:0] count;

  logic [31:0]                   nmag_in;
  logic [31:0]                   dmag_in;
  logic [32:0]                   trial;
  logic                          fits;
  logic [31:0]                   rem_step;
  logic [skf_pkg::DIV_BITS-1:0]  quo_step;

  assign nmag_in = numer[31] ? (~numer + 32'd1) : numer;
  assign dmag_in = denom[31] ? (~denom + 32'd1) : denom;

  assign trial    = {rem, quo[skf_pkg::DIV_BITS-1]};
  assign fits     = trial >= {1'b0, dmag};
  assign rem_step = fits ? 32'(trial - {1'b0, dmag}) : trial[31:0];
  assign quo_step = {quo[skf_pkg::DIV_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      count  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        if (denom == '0) begin
          status.done <= 1'b1;
        end else begin
          status.busy <= 1'b1;
          count       <= '0;
        end
      end else if (status.busy) begin
        count <= count + 1'b1;
        if (count == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_BITS - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= {nmag_in, 16'd0};
      rem  <= '0;
      dmag <= dmag_in;
      neg  <= numer[31] ^ denom[31];
      if (denom == '0) begin
        quotient <= numer[31] ? skf_pkg::GAIN_SAT_NEG : skf_pkg::GAIN_SAT_POS;
      end
    end else if (status.busy) begin
      quo <= quo_step;
      rem <= rem_step;
      // low 32 bits of the signed quotient
      quotient <= neg ? (~quo_step[31:0] + 32'd1) : quo_step[31:0];
    end
  end

endmodule

/* hw/rtl/scalar_kalman_tilt_filter.sv */
// scalar kalman tilt filter: one shared multiplier and one shared divider
// under a small sequencer; without a correction a sample runs the delta multiply,
// delta add and finish states; with one it also waits on the serial divider (which
// saturates the gain without dividing when p+r is zero) and runs the covariance steps;
// the next sample is taken once the sequencer is back in idle
// synchronous active-high reset: angles clear, covariance 100.0, noise 0.1

module scalar_kalman_tilt_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [skf_pkg::NOISE_W-1:0]    cfg_wdata,
  skf_sample_if.sink                     sample,
  skf_result_if.source                   result
);

  skf_pkg::seq_state_t  state;
  skf_pkg::seq_state_t  state_next;

  skf_pkg::fx_t         angle;
  skf_pkg::fx_t         gyro_angle;
  skf_pkg::fx_t         covariance;
  logic [skf_pkg::NOISE_W-1:0] noise;

  skf_pkg::fx_t         rate;
  skf_pkg::fx_t         meas;
  logic                 upd;
  skf_pkg::fx_t         gain;
  skf_pkg::fx_t         partial;

  skf_pkg::fx_t         mul_a;
  skf_pkg::fx_t         mul_b;
  skf_pkg::fx_t         mul_res;
  logic                 div_start;
  skf_pkg::fx_t         div_res;
  skf_pkg::div_status_t div_status;

  logic                 out_valid;
  logic                 out_load;
  logic                 in_take;
  skf_pkg::fx_t         noise_fx;

  assign noise_fx  = {1'b0, noise};
  assign in_take   = sample.valid && sample.ready;

  skf_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_res)
  );

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (covariance),
    .denom    (32'(covariance + noise_fx)),
    .quotient (div_res),
    .status   (div_status)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skf_pkg::S_IDLE:      if (in_take) state_next = skf_pkg::S_MUL_DELTA;
      skf_pkg::S_MUL_DELTA: state_next = skf_pkg::S_ADD_DELTA;
      skf_pkg::S_ADD_DELTA: state_next = upd ? skf_pkg::S_DIV_START : skf_pkg::S_FINISH;
      skf_pkg::S_DIV_START: state_next = skf_pkg::S_DIV_WAIT;
      skf_pkg::S_DIV_WAIT:  if (div_status.done) state_next = skf_pkg::S_MUL_INNOV;
      skf_pkg::S_MUL_INNOV: state_next = skf_pkg::S_ADD_INNOV;
      skf_pkg::S_ADD_INNOV: state_next = skf_pkg::S_MUL_PA;
      skf_pkg::S_MUL_PA:    state_next = skf_pkg::S_MUL_GG;
      skf_pkg::S_MUL_GG:    state_next = skf_pkg::S_MUL_RC;
      skf_pkg::S_MUL_RC:    state_next = skf_pkg::S_ADD_COV;
      skf_pkg::S_ADD_COV:   state_next = skf_pkg::S_FINISH;
      skf_pkg::S_FINISH:    if (out_load) state_next = skf_pkg::S_IDLE;
      default:              state_next = skf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: operand selection and unit starts
  always_comb begin
    sample.ready = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    mul_a        = rate;
    mul_b        = skf_pkg::STEP_DT;
    unique case (state)
      skf_pkg::S_IDLE:      sample.ready = 1'b1;
      skf_pkg::S_MUL_DELTA: begin
        mul_a = rate;
        mul_b = skf_pkg::STEP_DT;
      end
      skf_pkg::S_DIV_START: div_start = 1'b1;
      skf_pkg::S_MUL_INNOV: begin
        mul_a = gain;
        mul_b = meas - angle;
      end
      skf_pkg::S_ADD_INNOV: begin
        // (1-k)^2
        mul_a = skf_pkg::ONE - gain;
        mul_b = skf_pkg::ONE - gain;
      end
      skf_pkg::S_MUL_PA: begin
        mul_a = covariance;
        mul_b = mul_res;
      end
      skf_pkg::S_MUL_GG: begin
        mul_a = gain;
        mul_b = gain;
      end
      skf_pkg::S_MUL_RC: begin
        mul_a = noise_fx;
        mul_b = mul_res;
      end
      skf_pkg::S_FINISH:    out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= skf_pkg::S_IDLE;
      angle      <= '0;
      gyro_angle <= '0;
      covariance <= skf_pkg::COV_RESET;
      noise      <= skf_pkg::NOISE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        noise <= cfg_wdata;
      end
      unique case (state)
        skf_pkg::S_IDLE: begin
          if (in_take) covariance <= covariance + skf_pkg::COV_STEP;
        end
        skf_pkg::S_ADD_DELTA: begin
          angle      <= angle + mul_res;
          gyro_angle <= gyro_angle + mul_res;
        end
        skf_pkg::S_ADD_INNOV: angle      <= angle + mul_res;
        skf_pkg::S_ADD_COV:   covariance <= partial + mul_res;
        default: ;
      endcase
      // result register frees the sequencer while a result waits
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, intermediate and result data registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      rate <= sample.gyro_rate;
      meas <= sample.measured_angle;
      upd  <= sample.run_update;
    end
    if (state == skf_pkg::S_DIV_WAIT && div_status.done) begin
      gain <= div_res;
    end
    if (state == skf_pkg::S_MUL_GG) begin
      partial <= mul_res;
    end
    if (out_load) begin
      result.angle_estimate  <= angle;
      result.gyro_only_angle <= gyro_angle;
    end
  end

  assign result.valid = out_valid;

`ifndef ASSERT_OFF
  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.busy |-> state == skf_pkg::S_DIV_WAIT)
    else $error("divider busy outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == skf_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_take_starts_seq: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == skf_pkg::S_MUL_DELTA)
    else $error("sample transfer did not start the sequence");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == skf_pkg::S_FINISH && out_valid && !result.ready)
    |=> state == skf_pkg::S_FINISH)
    else $error("result overwritten before its transfer");
`endif

endmodule

/* test/scalar_kalman_tilt_filter_tb.sv */
// self-checking testbench for scalar_kalman_tilt_filter: directed and random samples,
// a fixed-point tracker predicts both angles for every sample transfer
// depends on skf_pkg, skf_sample_if and skf_result_if from the rtl

module scalar_kalman_tilt_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef skf_pkg::fx_t fx_t;
  localparam int NOISE_W = skf_pkg::NOISE_W;

  localparam fx_t UNITY_FX       = 32'h0001_0000;
  localparam fx_t PROC_NOISE_FX  = 32'd655;
  localparam fx_t STEP_DT_FX     = 32'd262;
  localparam fx_t COV_START      = 32'd6553600;
  localparam fx_t GAIN_CLAMP_POS = 32'h7FFF_FFFF;
  localparam fx_t GAIN_CLAMP_NEG = 32'h8000_0000;

  localparam logic [NOISE_W-1:0] NOISE_DEFAULT = 31'd6554;
  localparam logic [NOISE_W-1:0] NOISE_MAX     = 31'h7FFF_FFFF;
  localparam logic [NOISE_W-1:0] NOISE_ZERO    = 31'd0;
  localparam logic [NOISE_W-1:0] NOISE_MIN     = 31'd1;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 400;

  typedef struct packed {
    fx_t angle;
    fx_t gyro;
  } tilt_angles_t;

  class tilt_tracker;
    fx_t angle_est;
    fx_t gyro_angle;
    fx_t cov;
    logic [NOISE_W-1:0] noise;
    tilt_angles_t expected_angles_q[$];
    int unsigned n_fail;
    int unsigned n_samples;
    int unsigned n_corrections;
    int unsigned n_zero_div;
    int unsigned n_checked;

    function new();
      angle_est  = '0;
      gyro_angle = '0;
      cov        = COV_START;
      noise      = NOISE_DEFAULT;
    endfunction

    // 16.16 product, floor shift, low 32 bits kept
    function fx_t fx_mul(fx_t a, fx_t b);
      longint prod;
      prod = longint'($signed(a)) * longint'($signed(b));
      return prod[47:16];
    endfunction

    // quotient truncated toward zero, low 32 bits kept
    function fx_t fx_div(fx_t a, fx_t b);
      longint num;
      longint den;
      longint quo;
      num = longint'($signed(a)) * 64'sd65536;
      den = longint'($signed(b));
      if (den == 0) return a[31] ? GAIN_CLAMP_NEG : GAIN_CLAMP_POS;
      quo = num / den;
      return quo[31:0];
    endfunction

    function void track_sample(fx_t rate, fx_t meas, logic correct);
      fx_t delta;
      fx_t sum;
      fx_t gain;
      fx_t omk;
      cov = cov + fx_mul(PROC_NOISE_FX, STEP_DT_FX);
      delta = fx_mul(rate, STEP_DT_FX);
      angle_est = angle_est + delta;
      gyro_angle = gyro_angle + delta;
      if (correct) begin
        sum = cov + fx_t'(noise);
        if (sum == '0) n_zero_div++;
        gain = fx_div(cov, sum);
        angle_est = angle_est + fx_mul(gain, meas - angle_est);
        omk = UNITY_FX - gain;
        cov = fx_mul(cov, fx_mul(omk, omk)) + fx_mul(fx_t'(noise), fx_mul(gain, gain));
        n_corrections++;
      end
      n_samples++;
      expected_angles_q.push_back('{angle: angle_est, gyro: gyro_angle});
    endfunction

    function void compare_angles(fx_t angle, fx_t gyro);
      tilt_angles_t want;
      if (expected_angles_q.size() == 0) begin
        $error("result transfer with nothing pending: angle_estimate=%h gyro_only_angle=%h",
               angle, gyro);
        n_fail++;
        return;
      end
      want = expected_angles_q.pop_front();
      n_checked++;
      if (angle !== want.angle) begin
        $error("angle_estimate: expected %h, got %h", want.angle, angle);
        n_fail++;
      end
      if (gyro !== want.gyro) begin
        $error("gyro_only_angle: expected %h, got %h", want.gyro, gyro);
        n_fail++;
      end
    endfunction

    function int unsigned pending();
      return expected_angles_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [NOISE_W-1:0]  cfg_wdata = '0;
  int                  snd_idle_pct = 0;
  int                  rcv_idle_pct = 0;
  int                  stall_cycles = 0;
  tilt_tracker         tracker;

  skf_sample_if sample_ch ();
  skf_result_if result_ch ();

  scalar_kalman_tilt_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        tracker.track_sample(sample_ch.gyro_rate, sample_ch.measured_angle,
                             sample_ch.run_update);
      if (result_ch.valid && result_ch.ready)
        tracker.compare_angles(result_ch.angle_estimate, result_ch.gyro_only_angle);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, tracker.pending());
        $display("scalar_kalman_tilt_filter: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(fx_t rate, fx_t meas, logic correct);
    while ($urandom_range(99) < snd_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.gyro_rate      <= rate;
    sample_ch.measured_angle <= meas;
    sample_ch.run_update     <= correct;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // step past the next edge first so the monitor has logged the last sample transfer
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_noise(logic [NOISE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.noise = value;
  endtask

  task automatic send_random(int count);
    fx_t rate;
    fx_t meas;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: rate = $urandom;
        1: begin
          case ($urandom_range(3))
            0: rate = 32'h7FFF_FFFF;
            1: rate = 32'h8000_0000;
            2: rate = 32'hFFFF_FFFF;
            default: rate = '0;
          endcase
        end
        // up to 64 degrees per second either way
        default: rate = fx_t'($urandom_range(32'h007F_FFFF)) - 32'h0040_0000;
      endcase
      if ($urandom_range(4) == 0)
        meas = $urandom;
      else
        meas = tracker.angle_est + fx_t'($urandom_range(32'h0007_FFFF)) - 32'h0004_0000;
      send_sample(rate, meas, $urandom_range(99) < 40);
    end
  endtask

  // full-scale noise makes p+r wrap negative, the gain turns negative and the
  // covariance runs away until quotients no longer fit; then aim p+r at zero
  task automatic drive_gain_runaway();
    fx_t next_cov;
    fx_t target;
    logic hit;
    hit = 1'b0;
    write_noise(NOISE_MAX);
    for (int attempt = 0; attempt < 8 && !hit; attempt++) begin
      repeat (attempt == 0 ? 160 : 40)
        send_sample(fx_t'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000, $urandom, 1'b1);
      drain();
      next_cov = tracker.cov + tracker.fx_mul(PROC_NOISE_FX, STEP_DT_FX);
      target = '0 - next_cov;
      if (!target[31]) begin
        write_noise(target[NOISE_W-1:0]);
        send_sample($urandom, $urandom, 1'b1);
        drain();
        hit = 1'b1;
      end
    end
    // zero noise gives a unit gain and pulls the covariance back to zero
    write_noise(NOISE_ZERO);
    repeat (3) send_sample(fx_t'($urandom_range(32'hFFFF)), $urandom, 1'b1);
    drain();
  endtask

  initial begin
    tracker = new();
    sample_ch.valid          <= 1'b0;
    sample_ch.gyro_rate      <= '0;
    sample_ch.measured_angle <= '0;
    sample_ch.run_update     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under the reset noise value
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 32'h8000_0000, 1'b1);
    send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    drain();
    write_noise(NOISE_MIN);
    send_sample(32'h0000_8000, 32'h0002_0000, 1'b1);
    send_sample(32'hFFFF_8000, 32'hFFFE_0000, 1'b1);
    drain();
    write_noise(NOISE_ZERO);
    send_sample(32'h0000_4000, $urandom, 1'b1);
    send_sample(32'hFFFF_C000, $urandom, 1'b1);
    drain();
    write_noise(NOISE_MAX);
    send_sample(32'h0000_1000, 32'h0010_0000, 1'b1);
    send_sample(32'hFFFF_F000, 32'hFFF0_0000, 1'b1);
    drain();

    snd_idle_pct = 34;
    rcv_idle_pct = 87;
    write_noise(NOISE_DEFAULT);
    send_random(PHASE_ITEMS);
    drain();

    snd_idle_pct = 87;
    rcv_idle_pct = 34;
    drive_gain_runaway();
    write_noise(NOISE_W'($urandom_range(32'h0010_0000, 1)));
    send_random(PHASE_ITEMS);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_noise(NOISE_W'($urandom_range(32'h0100_0000, 1)));
    send_random(PHASE_ITEMS);
    drain();

    repeat (64) @(posedge clk);
    $display("checked %0d results for %0d samples, %0d of them corrections",
             tracker.n_checked, tracker.n_samples, tracker.n_corrections);
    $display("noise from zero to full scale, %0d zero-divisor gains, wrapped angles",
             tracker.n_zero_div);
    if (tracker.n_fail == 0)
      $display("scalar_kalman_tilt_filter: match");
    else
      $display("scalar_kalman_tilt_filter: mismatch");
    $finish;
  end

endmodule
